// ===== hw/rtl/lm_pkg.sv =====
// list median package: word types for the request and response channels
// and the operation codes of the shared adder unit
// no dependencies
`timescale 1ns / 1ps

package lm_pkg;

   localparam int VALUE_W = 16;
   localparam int SUM_W   = VALUE_W + 1;
   localparam int COUNT_W = 7;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      has_value;
      logic                      last;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] median;
      logic        [COUNT_W-1:0] element_count;
      logic                      overflowed;
   } rsp_type;

   typedef enum logic [1:0] {
      ALU_SUB = 2'b01,
      ALU_ADD = 2'b10
   } alu_op_type;

endpackage

// ===== hw/rtl/lm_store.sv =====
// list median sorted store: single write port, single registered read port
// depends on lm_pkg
`timescale 1ns / 1ps

module lm_store #(
   parameter int MAX_VALUES = 64,
   localparam int AW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [AW-1:0]                     wr_addr,
   input  logic signed [lm_pkg::VALUE_W-1:0] wr_data,
   input  logic [AW-1:0]                     rd_addr,
   output logic signed [lm_pkg::VALUE_W-1:0] rd_data
);

   logic signed [lm_pkg::VALUE_W-1:0] mem [MAX_VALUES];
   logic signed [lm_pkg::VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/lm_alu.sv =====
// list median shared adder: 17 bit signed add or subtract, used for the
// insertion compare and for the sum of the two middle entries
// depends on lm_pkg
`timescale 1ns / 1ps

module lm_alu (
   input  lm_pkg::alu_op_type                op,
   input  logic signed [lm_pkg::VALUE_W-1:0] a,
   input  logic signed [lm_pkg::VALUE_W-1:0] b,
   output logic signed [lm_pkg::SUM_W-1:0]   res
);

   logic signed [lm_pkg::SUM_W-1:0] a_ext;
   logic signed [lm_pkg::SUM_W-1:0] b_ext;

   assign a_ext = {a[lm_pkg::VALUE_W-1], a};
   assign b_ext = {b[lm_pkg::VALUE_W-1], b};

   always_comb begin
      unique case (op)
         lm_pkg::ALU_SUB: res = a_ext - b_ext;
         lm_pkg::ALU_ADD: res = a_ext + b_ext;
         default:         res = a_ext + b_ext;
      endcase
   end

endmodule

// ===== hw/rtl/list_median.sv =====
// list median top level: insertion sequencer, median readout and response
// register around the sorted store and the shared adder
// depends on lm_pkg, lm_store, lm_alu
//
//   channel | ports                          | word
//   --------+--------------------------------+-------------------------------
//   request | req_valid req_ready req_data   | value, has_value, last
//   result  | rsp_valid rsp_ready rsp_data   | median, element_count, overflowed
//
// one request word at a time; req_ready is high only while the sequencer idles
// an insertion steps through READ and CMP once per store entry compared, then PLACE,
// one entry at a time, set by the one read port of the store and the adder
// a last word then runs the median readout: MED_ADDR, then MED_LO and MED_SUM as the count needs, then OUT
// a result waits in the response register; a new result stalls until it is taken
// reset clears count, overflow flag, response valid and sequencer; the store needs no clearing
`timescale 1ns / 1ps

module list_median #(
   parameter int MAX_VALUES = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  lm_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output lm_pkg::rsp_type rsp_data
);

   localparam int AW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
   localparam int CW = $clog2(MAX_VALUES + 1);

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_READ     = 8'b0000_0010,
      ST_CMP      = 8'b0000_0100,
      ST_PLACE    = 8'b0000_1000,
      ST_MED_ADDR = 8'b0001_0000,
      ST_MED_LO   = 8'b0010_0000,
      ST_MED_SUM  = 8'b0100_0000,
      ST_OUT      = 8'b1000_0000
   } state_type;

   state_type                         state_ff, state_in;
   logic [CW-1:0]                     pos_ff, pos_in;
   logic [CW-1:0]                     count_ff, count_in;
   logic                              ovf_ff, ovf_in;
   lm_pkg::req_type                   word_ff, word_in;
   logic signed [lm_pkg::VALUE_W-1:0] lo_ff, lo_in;
   logic signed [lm_pkg::VALUE_W-1:0] med_ff, med_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   lm_pkg::rsp_type                   rsp_ff, rsp_in;

   logic                              wr_en;
   logic [AW-1:0]                     wr_addr;
   logic signed [lm_pkg::VALUE_W-1:0] wr_data;
   logic [AW-1:0]                     rd_addr;
   logic signed [lm_pkg::VALUE_W-1:0] rd_data;

   lm_pkg::alu_op_type                alu_op;
   logic signed [lm_pkg::VALUE_W-1:0] alu_a;
   logic signed [lm_pkg::VALUE_W-1:0] alu_b;
   logic signed [lm_pkg::SUM_W-1:0]   alu_res;

   logic [CW-1:0]                     half;
   logic [CW-1:0]                     pos_dec;

   lm_store #(
      .MAX_VALUES (MAX_VALUES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lm_alu u_alu (
      .op  (alu_op),
      .a   (alu_a),
      .b   (alu_b),
      .res (alu_res)
   );

   assign half    = count_ff >> 1;
   assign pos_dec = pos_ff - CW'(1);

   function automatic logic [AW-1:0] pos_dec_half(input logic [CW-1:0] h);
      logic [CW-1:0] d;
      d = h - CW'(1);
      return d[AW-1:0];
   endfunction

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      word_in      = word_ff;
      lo_in        = lo_ff;
      med_in       = med_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_ff[AW-1:0];
      wr_data      = word_ff.value;
      rd_addr      = pos_dec[AW-1:0];
      alu_op       = lm_pkg::ALU_SUB;
      alu_a        = word_ff.value;
      alu_b        = rd_data;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               word_in = req_data;
               pos_in  = count_ff;
               if (req_data.has_value) begin
                  if (count_ff >= CW'(MAX_VALUES)) begin
                     ovf_in   = 1'b1;
                     state_in = req_data.last ? ST_MED_ADDR : ST_IDLE;
                  end else if (count_ff == '0) begin
                     state_in = ST_PLACE;
                  end else begin
                     state_in = ST_READ;
                  end
               end else begin
                  state_in = req_data.last ? ST_MED_ADDR : ST_IDLE;
               end
            end
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            // stored entry above the new value moves up one place
            if (alu_res[lm_pkg::SUM_W-1]) begin
               wr_en    = 1'b1;
               wr_data  = rd_data;
               pos_in   = pos_dec;
               state_in = (pos_dec == '0) ? ST_PLACE : ST_READ;
            end else begin
               state_in = ST_PLACE;
            end
         end
         ST_PLACE: begin
            wr_en    = 1'b1;
            count_in = count_ff + CW'(1);
            state_in = word_ff.last ? ST_MED_ADDR : ST_IDLE;
         end
         ST_MED_ADDR: begin
            if (count_ff == '0) begin
               med_in   = '0;
               state_in = ST_OUT;
            end else begin
               rd_addr  = count_ff[0] ? half[AW-1:0] : pos_dec_half(half);
               state_in = ST_MED_LO;
            end
         end
         ST_MED_LO: begin
            if (count_ff[0]) begin
               med_in   = rd_data;
               state_in = ST_OUT;
            end else begin
               lo_in    = rd_data;
               rd_addr  = half[AW-1:0];
               state_in = ST_MED_SUM;
            end
         end
         ST_MED_SUM: begin
            alu_op   = lm_pkg::ALU_ADD;
            alu_a    = lo_ff;
            alu_b    = rd_data;
            med_in   = alu_res[lm_pkg::SUM_W-1:1];
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_in.median        = med_ff;
               rsp_in.element_count = lm_pkg::COUNT_W'(count_ff);
               rsp_in.overflowed    = ovf_ff;
               count_in             = '0;
               ovf_in               = 1'b0;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      word_ff <= word_in;
      lo_ff   <= lo_in;
      med_ff  <= med_in;
      rsp_ff  <= rsp_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== tb/testbench.sv =====
// testbench for list_median: directed table of list words, then random lists,
// each median checked against the table or a sorted-list predictor in this file
// depends on lm_pkg and list_median
`timescale 1ns / 1ps

module testbench;

   localparam int MAX_VALUES    = 64;
   localparam int RANDOM_WORDS  = 340;
   localparam int IDLE_LIMIT    = 4000;
   localparam int DRAIN_CYCLES  = 2 * MAX_VALUES + 16;
   localparam int HOLD_OFF      = 400;
   localparam int HOLD_OFF_AT   = 4;
   localparam int REPORT_LIMIT  = 10;
   localparam int DIRECTED_ROWS = 22;

   typedef struct packed {
      lm_pkg::req_type word;
      logic            fixed_rsp;
      lm_pkg::rsp_type want;
   } list_row_type;

   localparam lm_pkg::rsp_type NO_RSP = '{16'h0000, 7'd0, 1'b0};

   // empty lists, extremes, floor of odd sums, ignored words, equal values
   localparam list_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{'{16'h0000, 1'b0, 1'b1}, 1'b1, '{16'h0000, 7'd0, 1'b0}},
      '{'{16'h7fff, 1'b1, 1'b1}, 1'b1, '{16'h7fff, 7'd1, 1'b0}},
      '{'{16'h8000, 1'b1, 1'b1}, 1'b1, '{16'h8000, 7'd1, 1'b0}},
      '{'{16'h7fff, 1'b1, 1'b0}, 1'b0, NO_RSP},
      '{'{16'h7fff, 1'b1, 1'b1}, 1'b1, '{16'h7fff, 7'd2, 1'b0}},
      '{'{16'h8000, 1'b1, 1'b0}, 1'b0, NO_RSP},
      '{'{16'h8000, 1'b1, 1'b1}, 1'b1, '{16'h8000, 7'd2, 1'b0}},
      '{'{16'h8000, 1'b1, 1'b0}, 1'b0, NO_RSP},
      '{'{16'h7fff, 1'b1, 1'b1}, 1'b1, '{16'hffff, 7'd2, 1'b0}},
      '{'{16'hffff, 1'b0, 1'b0}, 1'b0, NO_RSP},
      '{'{16'h0001, 1'b1, 1'b0}, 1'b0, NO_RSP},
      '{'{16'h0000, 1'b1, 1'b0}, 1'b0, NO_RSP},
      '{'{16'h5a5a, 1'b0, 1'b0}, 1'b0, NO_RSP},
      '{'{16'hffff, 1'b1, 1'b1}, 1'b1, '{16'h0000, 7'd3, 1'b0}},
      '{'{16'h0005, 1'b1, 1'b0}, 1'b0, NO_RSP},
      '{'{16'h0005, 1'b1, 1'b0}, 1'b0, NO_RSP},
      '{'{16'h0003, 1'b1, 1'b0}, 1'b0, NO_RSP},
      '{'{16'h0005, 1'b1, 1'b1}, 1'b0, NO_RSP},
      '{'{16'h1234, 1'b1, 1'b0}, 1'b0, NO_RSP},
      '{'{16'hff00, 1'b1, 1'b0}, 1'b0, NO_RSP},
      '{'{16'h0080, 1'b0, 1'b1}, 1'b0, NO_RSP},
      '{'{16'h0000, 1'b0, 1'b1}, 1'b1, '{16'h0000, 7'd0, 1'b0}}
   };

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   lm_pkg::req_type req_data;
   logic            rsp_valid;
   logic            rsp_ready;
   lm_pkg::rsp_type rsp_data;

   logic signed [lm_pkg::VALUE_W-1:0] sorted_list [$];
   logic                              list_overflow;
   lm_pkg::rsp_type                   pending_medians [$];
   lm_pkg::rsp_type                   oldest_median;

   int  failures;
   int  medians_checked;
   int  overflowed_lists;
   int  words_sent;
   int  idle_cycles;
   bit  sender_eager;

   list_median #(
      .MAX_VALUES(MAX_VALUES)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // insert into the sorted list after equal values; on a last word give the median
   function automatic bit sort_and_take_median(input lm_pkg::req_type w,
                                               output lm_pkg::rsp_type m);
      int                              pos;
      int                              n;
      logic signed [lm_pkg::SUM_W-1:0] pair_sum;
      m = NO_RSP;
      if (w.has_value) begin
         if (sorted_list.size() >= MAX_VALUES) begin
            list_overflow = 1'b1;
         end else begin
            pos = sorted_list.size();
            while (pos > 0 && sorted_list[pos-1] > w.value) pos--;
            sorted_list.insert(pos, w.value);
         end
      end
      if (!w.last) return 1'b0;
      n = sorted_list.size();
      if (n == 0) begin
         m.median = '0;
      end else if (n % 2 == 1) begin
         m.median = sorted_list[n/2];
      end else begin
         pair_sum = lm_pkg::SUM_W'(sorted_list[n/2-1]) + lm_pkg::SUM_W'(sorted_list[n/2]);
         m.median = pair_sum[lm_pkg::SUM_W-1:1];
      end
      m.element_count = lm_pkg::COUNT_W'(n);
      m.overflowed = list_overflow;
      sorted_list.delete();
      list_overflow = 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [lm_pkg::VALUE_W-1:0] draw_value();
      unique case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
         1: return lm_pkg::VALUE_W'(int'($urandom_range(0, 8)) - 4);
         default: return lm_pkg::VALUE_W'($urandom);
      endcase
   endfunction

   task automatic send_word(input lm_pkg::req_type w, input bit fixed_rsp,
                            input lm_pkg::rsp_type want);
      int              gap;
      lm_pkg::rsp_type predicted;
      gap = sender_eager ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      if (sort_and_take_median(w, predicted))
         pending_medians.push_back(fixed_rsp ? want : predicted);
   endtask

   // stimulus
   initial begin
      int              i;
      int              k;
      int              len;
      int              list_no;
      int              random_words;
      bit              close_with_value;
      lm_pkg::req_type w;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      list_overflow = 1'b0;
      sender_eager = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIRECTED_ROWS; i++)
         send_word(DIRECTED[i].word, DIRECTED[i].fixed_rsp, DIRECTED[i].want);

      // random lists: first one overfills the store, second one fills it exactly
      list_no = 0;
      random_words = 0;
      while (random_words < RANDOM_WORDS) begin
         sender_eager = ($urandom_range(0, 3) == 0);
         if (list_no == 0)
            len = MAX_VALUES + 2;
         else if (list_no == 1)
            len = MAX_VALUES;
         else if ($urandom_range(0, 29) == 0)
            len = $urandom_range(MAX_VALUES - 4, MAX_VALUES + 6);
         else
            len = $urandom_range(0, 9);
         close_with_value = (len > 0) && ($urandom_range(0, 1) == 1);
         for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0) begin
               w.value = lm_pkg::VALUE_W'($urandom);
               w.has_value = 1'b0;
               w.last = 1'b0;
               send_word(w, 1'b0, NO_RSP);
            end
            w.value = draw_value();
            w.has_value = 1'b1;
            w.last = close_with_value && (k == len - 1);
            send_word(w, 1'b0, NO_RSP);
            random_words++;
         end
         if (!close_with_value) begin
            w.value = lm_pkg::VALUE_W'($urandom);
            w.has_value = 1'b0;
            w.last = 1'b1;
            send_word(w, 1'b0, NO_RSP);
            random_words++;
         end
         list_no++;
      end
      req_valid <= 1'b0;

      while (pending_medians.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_medians.size() != 0) begin
         $display("%0d medians never arrived", pending_medians.size());
         failures += pending_medians.size();
      end

      $display("%0d list words over %0d random lists, %0d medians checked",
               words_sent, list_no, medians_checked);
      $display("%0d lists overflowed the store, %0d mismatches", overflowed_lists, failures);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // result side: random stalls, eager stretches and one long hold-off
   initial begin
      int taken;
      int stall;
      rsp_ready <= 1'b0;
      taken = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (taken == HOLD_OFF_AT)
            stall = HOLD_OFF;
         else if ((taken / 16) % 3 == 0)
            stall = 0;
         else
            stall = $urandom_range(0, 8);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   // result checking
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_medians.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("%0t: unexpected median %0d count %0d overflowed %0b", $time,
                        rsp_data.median, rsp_data.element_count, rsp_data.overflowed);
         end else begin
            oldest_median = pending_medians.pop_front();
            medians_checked++;
            if (rsp_data.overflowed === 1'b1) overflowed_lists++;
            if (rsp_data.median !== oldest_median.median ||
                rsp_data.element_count !== oldest_median.element_count ||
                rsp_data.overflowed !== oldest_median.overflowed) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("%0t: expected median %0d count %0d overflowed %0b, got %0d %0d %0b",
                           $time, oldest_median.median, oldest_median.element_count,
                           oldest_median.overflowed, rsp_data.median,
                           rsp_data.element_count, rsp_data.overflowed);
            end
         end
      end
   end

   // watchdog on cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d cycles with no word moving", idle_cycles);
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

// ===== filelist.f =====
hw/rtl/lm_pkg.sv
hw/rtl/lm_store.sv
hw/rtl/lm_alu.sv
hw/rtl/list_median.sv
tb/testbench.sv
